FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DMSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmsp: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DMSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmsp: assertion failed");

// Next-cycle implication that also holds across reset.
`define DMSP_ASSERT_RST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dmsp: reset assertion failed");

`endif

FILE: rtl/dmsp_pkg.sv
// Shared widths, constants and control structs of the dual motor speed PID.
package dmsp_pkg;

  // Shared multiplier operand and product widths
  localparam int A_W = 39;
  localparam int B_W = 18;
  localparam int P_W = A_W + B_W;

  // Divider widths and step counts
  localparam int DIV_W       = 40;
  localparam int DIVS_W      = 28;
  localparam int Q_W         = 16;
  localparam int LONG_STEPS  = 16;
  localparam int SHORT_STEPS = 8;
  localparam int CNT_W       = $clog2(LONG_STEPS + 1);

  // Scaling constants
  localparam int MS_PER_S   = 1000;
  localparam int US_PER_S   = 1000000;
  localparam int FLOOR_NUM  = 3;
  localparam int DEN_SHIFT  = 8;

  // Divide by ten as a reciprocal multiply; exact for any 17-bit numerator
  localparam int FLOOR_RECIP = 52429;
  localparam int FLOOR_SHIFT = 19;

  // Configuration port
  localparam int CFG_W = 24;
  localparam int IDX_W = 3;

  typedef struct packed {
    logic [A_W-1:0] a;
    logic [B_W-1:0] b;
    logic           load;
    logic           add;
  } mul_ctl_t;

  typedef struct packed {
    logic              start;
    logic              short_mode;
    logic [DIV_W-1:0]  dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/dmsp_mul.sv
// Shared signed multiplier with a registered product and a numerator accumulator.
module dmsp_mul import dmsp_pkg::*; (
  input  logic                  clk,
  input  mul_ctl_t              ctl,
  output logic signed [P_W-1:0] prod,
  output logic signed [P_W-1:0] sum
);

  logic signed [P_W-1:0] prod_c;

  // Form the full signed product of the two operands
  assign prod_c = $signed(ctl.a) * $signed(ctl.b);

  // Register the product; load or add the previous product into the sum
  always_ff @(posedge clk) begin
    prod <= prod_c;
    if (ctl.load) begin
      sum <= prod;
    end else if (ctl.add) begin
      sum <= sum + prod;
    end
  end

endmodule

FILE: rtl/dmsp_div.sv
// Restoring divider, one quotient bit per cycle, 16 or 8 quotient bits.
module dmsp_div import dmsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0] rmd;
  logic [DIV_W-1:0] dd;
  logic [Q_W-1:0]   q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   diff;
  logic             ge;

  // Trial subtract of the shifted divisor
  assign diff = {1'b0, rmd} - {1'b0, dd};
  assign ge   = ~diff[DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // Load the dividend and align the divisor under the top quotient bit
        rmd  <= req.dividend;
        q    <= '0;
        busy <= 1'b1;
        if (req.short_mode) begin
          dd  <= DIV_W'(req.divisor) << (SHORT_STEPS - 1);
          cnt <= CNT_W'(SHORT_STEPS);
        end else begin
          dd  <= DIV_W'(req.divisor) << (LONG_STEPS - 1);
          cnt <= CNT_W'(LONG_STEPS);
        end
      end else if (busy) begin
        // Retire one quotient bit
        if (ge) begin
          rmd <= diff[DIV_W-1:0];
        end
        q   <= {q[Q_W-2:0], ge};
        dd  <= dd >> 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;

endmodule

FILE: rtl/dual_motor_speed_pid_with_taper_core.sv
// Top level: configuration, tick sequencer and PID state of the dual wheel speed controller.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------------
//   in      | input     | in_valid / in_ready    | restart, elapsed_ms, left/right_speed, travelled
//   out     | output    | out_valid / out_ready  | left_pwm, right_pwm, arrived
//   cfg     | input     | cfg_we (no wait)       | cfg_index, cfg_data
//
// An arrived tick or a tick with zero elapsed time goes from idle straight to the output state.
// A running tick steps through the error, integral and multiply states for each wheel, waits on
// the divider for a wheel whose PID value is not saturated, and first runs the taper states when
// the setpoint tapers (reciprocal multiplies). One shared multiplier and a bit-serial divider serve.
// Reset is synchronous: configuration registers return to their reset values and the PID state is cleared.
// in_ready is high only while the sequencer is idle; a stalled result holds in the output
// register and the sequencer waits for it to be taken before loading the next one.
module dual_motor_speed_pid_with_taper_core import dmsp_pkg::*; #(
  parameter int SLOWDOWN_COUNTS = 400
) (
  input  logic               clk,
  input  logic               rst,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  input  logic [9:0]         elapsed_ms,
  input  logic signed [15:0] left_speed,
  input  logic signed [15:0] right_speed,
  input  logic [23:0]        travelled,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         left_pwm,
  output logic [7:0]         right_pwm,
  output logic               arrived,
  // configuration writes
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int SLOW_W = $clog2(SLOWDOWN_COUNTS + 1);
  localparam int REM_W  = 25;
  localparam int SP_W   = 15;
  localparam int E_W    = 18;
  localparam int ET_W   = 28;
  localparam int INT_W  = 21;
  localparam int ACC_W  = 29;
  localparam int LIM_W  = 20;
  localparam int KT_W   = 20;

  // Taper reciprocal: the estimate is at most one below the true quotient
  localparam int     SP_SHIFT = SP_W + SLOW_W;
  localparam longint SP_RECIP = (longint'(1) << SP_SHIFT) / longint'(SLOWDOWN_COUNTS);

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_SPEED   = 3'd0,
    REG_TARGET_COUNT   = 3'd1,
    REG_GAIN_P         = 3'd2,
    REG_GAIN_I         = 3'd3,
    REG_GAIN_D         = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_MIN_PWM        = 3'd6,
    REG_MAX_PWM        = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SPM, S_SPD, S_SPW, S_FLD, S_FLW, S_ERR, S_MET, S_ACC,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_CMP, S_DIVW, S_UPD, S_OUT
  } state_t;

  // Configuration registers
  logic [14:0] target_speed;
  logic [23:0] target_count;
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic [9:0]  integral_limit;
  logic [7:0]  min_pwm;
  logic [7:0]  max_pwm;

  // Sequencer and tick registers
  state_t                   state;
  logic                     wheel;
  logic [9:0]               t_r;
  logic signed [15:0]       spd_q [2];
  logic [SLOW_W-1:0]        rem_lo;
  logic [SP_W-1:0]          sp_r;
  logic signed [E_W-1:0]    e_r;
  logic signed [E_W-1:0]    de_r;
  logic signed [INT_W-1:0]  acc_r;
  logic                     lt_r;
  logic [7:0]               duty_q [2];
  logic                     arr_r;

  // PID state
  logic signed [INT_W-1:0]  integ_q [2];
  logic signed [E_W-1:0]    last_q [2];

  // Datapath signals
  logic [REM_W-1:0]         rem_c;
  logic                     rem_le0;
  logic                     rem_lt;
  logic [KT_W-1:0]          kt;
  logic [DIVS_W-1:0]        den;
  logic [LIM_W-1:0]         lim_c;
  logic signed [ACC_W-1:0]  lim_s;
  logic signed [ACC_W-1:0]  acc_raw;
  logic signed [ACC_W-1:0]  acc_c;
  logic signed [E_W-1:0]    e_c;
  logic signed [E_W-1:0]    de_c;
  logic [16:0]              tgt3;
  logic [SP_W-1:0]          sp_q0;
  logic signed [P_W-1:0]    sp_rmd;
  logic [SP_W-1:0]          fl_c;
  logic signed [P_W-1:0]    prod;
  logic signed [P_W-1:0]    sum;
  logic signed [P_W-1:0]    bound;
  logic                     gt_c;
  mul_ctl_t                 mul_ctl;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Remaining distance and taper window
  assign rem_c   = {1'b0, target_count} - {1'b0, travelled};
  assign rem_le0 = rem_c[REM_W-1] || (rem_c == '0);
  assign rem_lt  = rem_c[REM_W-2:0] < (REM_W-1)'(SLOWDOWN_COUNTS);

  // Time scaling: t*1000 and the divisor 256000*t
  assign kt  = KT_W'(t_r) * KT_W'(MS_PER_S);
  assign den = {kt, DEN_SHIFT'(0)};

  // Integral clamp bound in count*ms
  assign lim_c = LIM_W'(integral_limit) * LIM_W'(MS_PER_S);
  assign lim_s = ACC_W'(lim_c);

  // Error and its change for the current wheel
  assign e_c  = E_W'(sp_r) - E_W'(spd_q[wheel]);
  assign de_c = e_c - last_q[wheel];

  // Integral update with clamp
  assign acc_raw = ACC_W'(integ_q[wheel]) + ACC_W'($signed(prod[ET_W-1:0]));
  always_comb begin
    if (acc_raw > lim_s) begin
      acc_c = lim_s;
    end else if (acc_raw < -lim_s) begin
      acc_c = -lim_s;
    end else begin
      acc_c = acc_raw;
    end
  end

  // Floor numerator 3*target_speed
  assign tgt3 = 17'(target_speed) * 17'(FLOOR_NUM);

  // Taper quotient estimate, its remainder, and the floor quotient
  assign sp_q0  = prod[SP_SHIFT +: SP_W];
  assign sp_rmd = sum - prod;
  assign fl_c   = prod[FLOOR_SHIFT +: SP_W];

  // Saturation bound: duty limit times the divisor
  assign bound = prod <<< DEN_SHIFT;
  assign gt_c  = sum > bound;

  assign in_ready = (state == S_IDLE);

  // Drive the shared multiplier
  always_comb begin
    mul_ctl = '0;
    case (state)
      S_SPM: begin
        mul_ctl.a = A_W'(target_speed);
        mul_ctl.b = B_W'(rem_lo);
      end
      S_SPD: begin
        mul_ctl.a    = prod[A_W-1:0];
        mul_ctl.b    = B_W'(SP_RECIP);
        mul_ctl.load = 1'b1;
      end
      S_SPW: begin
        mul_ctl.a = A_W'(sp_q0);
        mul_ctl.b = B_W'(SLOWDOWN_COUNTS);
      end
      S_FLD: begin
        mul_ctl.a = A_W'(FLOOR_RECIP);
        mul_ctl.b = B_W'(tgt3);
      end
      S_MET: begin
        mul_ctl.a = A_W'(e_r);
        mul_ctl.b = B_W'(t_r);
      end
      S_ACC: begin
        mul_ctl.a = A_W'(kt);
        mul_ctl.b = B_W'(e_r);
      end
      S_M1: begin
        mul_ctl.a = prod[A_W-1:0];
        mul_ctl.b = B_W'(gain_p);
      end
      S_M2: begin
        mul_ctl.a    = A_W'(acc_r);
        mul_ctl.b    = B_W'(gain_i);
        mul_ctl.load = 1'b1;
      end
      S_M3: begin
        mul_ctl.a = prod[A_W-1:0];
        mul_ctl.b = B_W'(t_r);
      end
      S_M4: begin
        mul_ctl.a   = A_W'(US_PER_S);
        mul_ctl.b   = B_W'(de_r);
        mul_ctl.add = 1'b1;
      end
      S_M5: begin
        mul_ctl.a = prod[A_W-1:0];
        mul_ctl.b = B_W'(gain_d);
      end
      S_M6: begin
        mul_ctl.a   = A_W'(kt);
        mul_ctl.b   = B_W'(min_pwm);
        mul_ctl.add = 1'b1;
      end
      S_M7: begin
        mul_ctl.a = A_W'(kt);
        mul_ctl.b = B_W'(max_pwm);
      end
      default: begin
        mul_ctl = '0;
      end
    endcase
  end

  // Drive the divider
  always_comb begin
    div_req = '0;
    case (state)
      S_CMP: begin
        div_req.start      = ~lt_r & ~gt_c;
        div_req.short_mode = 1'b1;
        div_req.dividend   = sum[DIV_W-1:0];
        div_req.divisor    = den;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  dmsp_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .prod (prod),
    .sum  (sum)
  );

  dmsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed   <= 15'd4836;
      target_count   <= 24'd16976;
      gain_p         <= 16'd2048;
      gain_i         <= 16'd512;
      gain_d         <= 16'd26;
      integral_limit <= 10'd50;
      min_pwm        <= 8'd70;
      max_pwm        <= 8'd255;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TARGET_SPEED:   target_speed   <= cfg_data[14:0];
        REG_TARGET_COUNT:   target_count   <= cfg_data[23:0];
        REG_GAIN_P:         gain_p         <= cfg_data[15:0];
        REG_GAIN_I:         gain_i         <= cfg_data[15:0];
        REG_GAIN_D:         gain_d         <= cfg_data[15:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[9:0];
        REG_MIN_PWM:        min_pwm        <= cfg_data[7:0];
        REG_MAX_PWM:        max_pwm        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, PID state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wheel      <= 1'b0;
      out_valid  <= 1'b0;
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      last_q[0]  <= '0;
      last_q[1]  <= '0;
    end else begin
      // Drop the result once taken, unless the next one loads in its place
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            t_r      <= elapsed_ms;
            spd_q[0] <= left_speed;
            spd_q[1] <= right_speed;
            rem_lo   <= rem_c[SLOW_W-1:0];
            sp_r     <= target_speed;
            wheel    <= 1'b0;
            if (restart) begin
              integ_q[0] <= '0;
              integ_q[1] <= '0;
              last_q[0]  <= '0;
              last_q[1]  <= '0;
            end
            if (rem_le0) begin
              duty_q[0] <= '0;
              duty_q[1] <= '0;
              arr_r     <= 1'b1;
              state     <= S_OUT;
            end else if (elapsed_ms == '0) begin
              duty_q[0] <= min_pwm;
              duty_q[1] <= min_pwm;
              arr_r     <= 1'b0;
              state     <= S_OUT;
            end else if (rem_lt) begin
              arr_r <= 1'b0;
              state <= S_SPM;
            end else begin
              arr_r <= 1'b0;
              state <= S_ERR;
            end
          end
        end
        S_SPM: state <= S_SPD;
        S_SPD: state <= S_SPW;
        S_SPW: begin
          sp_r  <= sp_q0;
          state <= S_FLD;
        end
        S_FLD: begin
          // Step the taper quotient up when the remainder reaches the divisor
          if (sp_rmd >= P_W'(SLOWDOWN_COUNTS)) begin
            sp_r <= sp_r + SP_W'(1);
          end
          state <= S_FLW;
        end
        S_FLW: begin
          // Hold the taper at its floor
          if (fl_c > sp_r) begin
            sp_r <= fl_c;
          end
          state <= S_ERR;
        end
        S_ERR: begin
          e_r   <= e_c;
          de_r  <= de_c;
          state <= S_MET;
        end
        S_MET: state <= S_ACC;
        S_ACC: begin
          acc_r <= acc_c[INT_W-1:0];
          state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: state <= S_M4;
        S_M4: state <= S_M5;
        S_M5: state <= S_M6;
        S_M6: state <= S_M7;
        S_M7: begin
          lt_r  <= sum < bound;
          state <= S_CMP;
        end
        S_CMP: begin
          // Saturate low first, then high, else divide
          if (lt_r) begin
            duty_q[wheel] <= min_pwm;
            state         <= S_UPD;
          end else if (gt_c) begin
            duty_q[wheel] <= max_pwm;
            state         <= S_UPD;
          end else begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            duty_q[wheel] <= div_rsp.quot[7:0];
            state         <= S_UPD;
          end
        end
        S_UPD: begin
          integ_q[wheel] <= acc_r;
          last_q[wheel]  <= e_r;
          if (!wheel) begin
            wheel <= 1'b1;
            state <= S_ERR;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // Advance once the output register is free
          if (!out_valid || out_ready) begin
            left_pwm  <= duty_q[0];
            right_pwm <= duty_q[1];
            arrived   <= arr_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/dmsp_chk.sv
// Port-level checker for the dual motor speed PID, bound to the top level.
`include "assert_macros.svh"

module dmsp_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] left_pwm,
  input logic [7:0] right_pwm,
  input logic       arrived
);

  // An arrived result drives both motors off
  `DMSP_ASSERT_IMP(a_arrived_off, out_valid && arrived, left_pwm == 8'd0 && right_pwm == 8'd0)

  // A stalled result holds
  `DMSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_pwm) && $stable(right_pwm) && $stable(arrived))

  // The block is busy in the cycle after taking a transaction
  `DMSP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // Reset leaves the block idle with no result pending
  `DMSP_ASSERT_RST_NXT(a_reset_idle, rst, !out_valid && in_ready)

endmodule

bind dual_motor_speed_pid_with_taper_core dmsp_chk u_dmsp_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .left_pwm  (left_pwm),
  .right_pwm (right_pwm),
  .arrived   (arrived)
);

FILE: tb/dual_motor_speed_pid_with_taper_core_test.sv
// Self-checking testbench for the dual wheel speed PID core with end-of-run taper.
`timescale 1ns / 1ps

module dual_motor_speed_pid_with_taper_core_test;
  import dmsp_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int TAPER_COUNTS  = 400;
  localparam int REG_COUNT     = 8;
  localparam int DIRECTED_ROWS = 18;
  localparam int PHASES        = 12;
  localparam int FIXED_PHASES  = 6;
  localparam int PHASE_TICKS   = 111;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 100;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 50;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_SPEED,
    REG_TARGET_COUNT,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_INTEGRAL_LIMIT,
    REG_MIN_PWM,
    REG_MAX_PWM
  } reg_idx_t;

  localparam int REG_WIDTH [REG_COUNT] = '{15, 24, 16, 16, 16, 10, 8, 8};

  typedef struct packed {
    logic               restart;
    logic [9:0]         elapsed_ms;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [23:0]        travelled;
  } tick_t;

  typedef struct packed {
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic       arrived;
  } duty_t;

  typedef struct packed {
    tick_t tick;
    logic  typed;
    duty_t want;
  } directed_row_t;

  // Opening ticks under the reset settings; the typed rows are arrivals and zero elapsed time
  directed_row_t directed_ticks [DIRECTED_ROWS] = '{
    '{'{1'b1, 10'd0,    16'h0000, 16'h0000, 24'd0},        1'b1, '{8'd70, 8'd70, 1'b0}},
    '{'{1'b0, 10'd10,   16'h0000, 16'h0000, 24'd0},        1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd10,   16'h0000, 16'h0000, 24'd16976},    1'b1, '{8'd0,  8'd0,  1'b1}},
    '{'{1'b0, 10'd1000, 16'h7FFF, 16'h8000, 24'hFFFFFF},   1'b1, '{8'd0,  8'd0,  1'b1}},
    '{'{1'b0, 10'd1000, 16'h7FFF, 16'h8000, 24'd0},        1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd1,    16'h8000, 16'h7FFF, 24'd0},        1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd20,   16'd4836, 16'd4836, 24'd16576},    1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd20,   16'd4800, 16'd4830, 24'd16577},    1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd20,   16'd1400, 16'd1500, 24'd16975},    1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd0,    16'd1000, 16'd1000, 24'd16000},    1'b1, '{8'd70, 8'd70, 1'b0}},
    '{'{1'b1, 10'd10,   16'h0000, 16'h0000, 24'd16976},    1'b1, '{8'd0,  8'd0,  1'b1}},
    '{'{1'b0, 10'd1000, 16'h0000, 16'h0000, 24'd0},        1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd1000, 16'h0000, 16'h0000, 24'd0},        1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd1000, 16'h7FFF, 16'h7FFF, 24'd0},        1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd1000, 16'h7FFF, 16'h7FFF, 24'd0},        1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b1, 10'd10,   16'd4830, 16'd4840, 24'd100},      1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd10,   16'd4836, 16'd4836, 24'd16975},    1'b0, '{8'd0,  8'd0,  1'b0}},
    '{'{1'b0, 10'd500,  16'hFFFF, 16'h0001, 24'd16977},    1'b1, '{8'd0,  8'd0,  1'b1}}
  };

  // Register settings: widest gains, all-zero duty, inverted limits, no distance, a middle setting, full duty
  int unsigned fixed_settings [FIXED_PHASES][REG_COUNT] = '{
    '{32767, 24'hFFFFFF, 65535, 65535, 65535, 1000, 0,   255},
    '{0,     800,        0,     0,     0,     0,    0,   0},
    '{1000,  3000,       256,   64,    0,     1,    255, 0},
    '{4836,  0,          2048,  512,   26,    50,   70,  255},
    '{300,   1200,       4096,  1024,  512,   10,   40,  200},
    '{20000, 5000,       65535, 0,     65535, 1000, 255, 255}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               restart = 1'b0;
  logic [9:0]         elapsed_ms = '0;
  logic signed [15:0] left_speed = '0;
  logic signed [15:0] right_speed = '0;
  logic [23:0]        travelled = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         left_pwm;
  logic [7:0]         right_pwm;
  logic               arrived;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Controller copy: registers at their reset values, wheel state cleared
  int unsigned        cfg_reg [REG_COUNT] = '{4836, 16976, 2048, 512, 26, 50, 70, 255};
  logic signed [31:0] wheel_acc [2] = '{0, 0};
  logic signed [17:0] wheel_prev [2] = '{0, 0};

  duty_t expected_duties [$];

  int mismatches    = 0;
  int ticks_sent    = 0;
  int results_seen  = 0;
  int arrived_seen  = 0;
  int inside_seen   = 0;
  int burst_left    = 0;
  bit steady_sender = 1'b0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  bit steady_ready  = 1'b1;
  int stall_period  = 2;
  int stall_len     = 1;
  int pattern_left  = 0;
  int pattern_pos   = 0;

  dual_motor_speed_pid_with_taper_core #(
    .SLOWDOWN_COUNTS(TAPER_COUNTS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .elapsed_ms (elapsed_ms),
    .left_speed (left_speed),
    .right_speed(right_speed),
    .travelled  (travelled),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_pwm   (left_pwm),
    .right_pwm  (right_pwm),
    .arrived    (arrived),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // One wheel loop: unless no time elapsed, advance its integral and last error; return the saturated duty
  function automatic logic [7:0] wheel_duty(input int side, input longint sp,
                                            input longint spd, input longint t);
    longint lo, hi, e, acc, lim, de, num, den;
    lo = longint'(cfg_reg[REG_MIN_PWM]);
    hi = longint'(cfg_reg[REG_MAX_PWM]);
    // no elapsed time: zero drive, lifted to the minimum duty, state held
    if (t == 0) return lo[7:0];
    e = sp - spd;
    lim = longint'(cfg_reg[REG_INTEGRAL_LIMIT]) * 1000;
    acc = longint'(wheel_acc[side]) + e * t;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    de = e - longint'(wheel_prev[side]);
    wheel_acc[side] = acc[31:0];
    wheel_prev[side] = e[17:0];
    num = longint'(cfg_reg[REG_GAIN_P]) * e * 1000 * t
        + longint'(cfg_reg[REG_GAIN_I]) * acc * t
        + longint'(cfg_reg[REG_GAIN_D]) * de * 1000000;
    den = 256000 * t;
    // lower limit is tested first so that inverted limits give the minimum
    if (num < lo * den) return lo[7:0];
    if (num > hi * den) return hi[7:0];
    return 8'(num / den);
  endfunction

  // Whole tick: restart, arrival test, tapered setpoint, then both wheels
  function automatic duty_t predict_duties(input tick_t tk);
    duty_t  res;
    longint rem, sp, floor_sp;
    if (tk.restart) begin
      wheel_acc = '{0, 0};
      wheel_prev = '{0, 0};
    end
    rem = longint'(cfg_reg[REG_TARGET_COUNT]) - longint'(tk.travelled);
    if (rem <= 0) begin
      res = '{8'd0, 8'd0, 1'b1};
      return res;
    end
    sp = longint'(cfg_reg[REG_TARGET_SPEED]);
    if (rem < TAPER_COUNTS) begin
      floor_sp = sp * 3 / 10;
      sp = sp * rem / TAPER_COUNTS;
      if (sp < floor_sp) sp = floor_sp;
    end
    res.left_pwm  = wheel_duty(0, sp, longint'($signed(tk.left_speed)),
                               longint'(tk.elapsed_ms));
    res.right_pwm = wheel_duty(1, sp, longint'($signed(tk.right_speed)),
                               longint'(tk.elapsed_ms));
    res.arrived   = 1'b0;
    return res;
  endfunction

  function automatic logic signed [15:0] speed_near(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    // keep the log short; every mismatch still counts
    if (mismatches < PRINT_LIMIT)
      $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_reg[idx] = value & ((32'd1 << REG_WIDTH[idx]) - 1);
  endtask

  // Offer one tick in bursts with random gaps; predict once the transaction is taken
  task automatic offer_tick(input tick_t tk, input logic typed, input duty_t typed_want);
    int    gap;
    duty_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    restart <= tk.restart;
    elapsed_ms <= tk.elapsed_ms;
    left_speed <= tk.left_speed;
    right_speed <= tk.right_speed;
    travelled <= tk.travelled;
    do @(posedge clk); while (!in_ready);
    want = predict_duties(tk);
    expected_duties.push_back(typed ? typed_want : want);
    ticks_sent++;
  endtask

  // Drop valid and wait until every result is back, leaving the core idle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: long hold-offs on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        steady_ready = ($urandom_range(0, 3) == 0);
        stall_period = $urandom_range(2, 9);
        stall_len = $urandom_range(1, stall_period - 1);
        pattern_left = $urandom_range(40, 400);
        pattern_pos = 0;
      end
      pattern_left--;
      pattern_pos = (pattern_pos + 1) % stall_period;
      out_ready <= steady_ready || (pattern_pos >= stall_len);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_duties
    duty_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_duties.size() == 0) begin
        report_mismatch("result with none outstanding", 1, 0);
      end else begin
        want = expected_duties.pop_front();
        if (left_pwm !== want.left_pwm) report_mismatch("left_pwm", left_pwm, want.left_pwm);
        if (right_pwm !== want.right_pwm)
          report_mismatch("right_pwm", right_pwm, want.right_pwm);
        if (arrived !== want.arrived) report_mismatch("arrived", arrived, want.arrived);
        if (want.arrived) arrived_seen++;
        else if (want.left_pwm > cfg_reg[REG_MIN_PWM] && want.left_pwm < cfg_reg[REG_MAX_PWM])
          inside_seen++;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out with %0d results outstanding", expected_duties.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    tick_t       tk;
    int unsigned setting [REG_COUNT];
    int unsigned position;
    int          sent;
    int          run_len;
    int          spread;

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed ticks under the reset settings
    for (int i = 0; i < DIRECTED_ROWS; i++)
      offer_tick(directed_ticks[i].tick, directed_ticks[i].typed, directed_ticks[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p < FIXED_PHASES) begin
        setting = fixed_settings[p];
      end else begin
        setting[REG_TARGET_SPEED] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                                : $urandom_range(100, 6000);
        setting[REG_TARGET_COUNT] = ($urandom_range(0, 7) == 0) ? ($urandom() & 24'hFFFFFF)
                                                                : $urandom_range(0, 5000);
        for (int g = REG_GAIN_P; g <= REG_GAIN_D; g++)
          setting[g] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 4096);
        setting[REG_INTEGRAL_LIMIT] = $urandom_range(0, 1000);
        setting[REG_MIN_PWM] = $urandom_range(0, 120);
        setting[REG_MAX_PWM] = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(setting[REG_MIN_PWM], 255);
      end
      for (int r = 0; r < REG_COUNT; r++)
        write_reg(reg_idx_t'(r), setting[r]);
      burst_left = 0;
      steady_sender = ($urandom_range(0, 3) == 0);
      // stall the output for a long stretch so the core backs up onto its input
      if (p == 0 || p == 7) hold_requests++;

      sent = 0;
      while (sent < PHASE_TICKS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: random field values, elapsed time at most 1000
          tk.restart = 1'($urandom_range(0, 1));
          tk.elapsed_ms = 10'($urandom_range(0, 1000));
          tk.left_speed = 16'($urandom());
          tk.right_speed = 16'($urandom());
          tk.travelled = 24'($urandom());
          offer_tick(tk, 1'b0, '0);
          sent++;
        end else begin
          // a run: restart, then ticks closing in on the target through the taper
          run_len = $urandom_range(4, 30);
          if ($urandom_range(0, 3) == 0 || cfg_reg[REG_TARGET_COUNT] <= 900)
            position = $urandom_range(0, cfg_reg[REG_TARGET_COUNT]);
          else
            position = cfg_reg[REG_TARGET_COUNT] - $urandom_range(0, 900);
          case ($urandom_range(0, 3))
            0: spread = 16;
            1: spread = 128;
            2: spread = 2048;
            default: spread = 40000;
          endcase
          for (int i = 0; i < run_len && sent < PHASE_TICKS; i++) begin
            tk.restart = (i == 0) || ($urandom_range(0, 29) == 0);
            tk.elapsed_ms = ($urandom_range(0, 14) == 0) ? 10'd0 : 10'($urandom_range(5, 60));
            tk.left_speed = speed_near(int'(cfg_reg[REG_TARGET_SPEED]), spread);
            tk.right_speed = speed_near(int'(cfg_reg[REG_TARGET_SPEED]), spread);
            tk.travelled = position[23:0];
            offer_tick(tk, 1'b0, '0);
            sent++;
            // advance the distance, now and then jumping back to break the run
            if ($urandom_range(0, 39) == 0) position = $urandom_range(0, position);
            else position = position + $urandom_range(0, 80);
            if (position > 24'hFFFFFF) position = 24'hFFFFFF;
          end
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d control ticks over %0d register settings, %0d long output stalls.",
             ticks_sent, PHASES + 1, hold_requests);
    $display("Checked %0d results: %0d arrived, %0d with left duty strictly inside its limits.",
             results_seen, arrived_seen, inside_seen);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: dual_motor_speed_pid_with_taper_core.f
+incdir+rtl
rtl/dmsp_pkg.sv
rtl/dmsp_mul.sv
rtl/dmsp_div.sv
rtl/dual_motor_speed_pid_with_taper_core.sv
rtl/dmsp_chk.sv
tb/dual_motor_speed_pid_with_taper_core_test.sv
